>>> rtl/vvfm_pkg.sv
// package for the voxel visible face mask unit: chunk sizes, opcodes and
// the command and status structs between controller and datapath
// no dependencies
`default_nettype none

package vvfm_pkg;

    localparam int SIZE    = 16;
    localparam int COORD_W = 4;
    localparam int DEPTH   = SIZE * SIZE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int HGT_W   = 5;
    localparam int MASK_W  = 6;
    localparam int CNT_W   = 3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FILL  = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    // column selector for memory address and capture
    typedef enum logic [2:0] {
        NB_C  = 3'd0,
        NB_XP = 3'd1,
        NB_XM = 3'd2,
        NB_YP = 3'd3,
        NB_YM = 3'd4
    } t_nb;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic wr_en;
        t_nb  sel;
        logic cap_en;
        t_nb  cap;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_st;

endpackage

`default_nettype wire

>>> rtl/vvfm_ctrl.sv
// controller state machine: sequences memory reads, writes and result load
// depends on vvfm_pkg
`default_nettype none

module vvfm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [1:0]       i_opcode,
    input  wire vvfm_pkg::t_dp_st i_st,
    output vvfm_pkg::t_dp_cmd     o_cmd
);
    import vvfm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR,
        S_XP,
        S_XM,
        S_YP,
        S_YM,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (i_opcode)
                        OP_WRITE: begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.sel   = NB_C;
                            n_state     = S_WR;
                        end
                        OP_FILL: begin
                            o_cmd.wr_en = 1'b1;
                            o_cmd.sel   = NB_C;
                        end
                        OP_QUERY: begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.sel   = NB_C;
                            n_state     = S_XP;
                        end
                        default: ;
                    endcase
                end
            end
            S_WR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.sel   = NB_C;
                n_state     = S_IDLE;
            end
            S_XP: begin
                o_cmd.cap_en = 1'b1;
                o_cmd.cap    = NB_C;
                o_cmd.rd_en  = 1'b1;
                o_cmd.sel    = NB_XP;
                n_state      = S_XM;
            end
            S_XM: begin
                o_cmd.cap_en = 1'b1;
                o_cmd.cap    = NB_XP;
                o_cmd.rd_en  = 1'b1;
                o_cmd.sel    = NB_XM;
                n_state      = S_YP;
            end
            S_YP: begin
                o_cmd.cap_en = 1'b1;
                o_cmd.cap    = NB_XM;
                o_cmd.rd_en  = 1'b1;
                o_cmd.sel    = NB_YP;
                n_state      = S_YM;
            end
            S_YM: begin
                o_cmd.cap_en = 1'b1;
                o_cmd.cap    = NB_YP;
                o_cmd.rd_en  = 1'b1;
                o_cmd.sel    = NB_YM;
                n_state      = S_FIN;
            end
            S_FIN: begin
                // -y column sits in the read register until the result is loaded
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/vvfm_dp.sv
// datapath: column memory with per-entry valid bits, item registers,
// neighbor captures and the result output register
// depends on vvfm_pkg
`default_nettype none

module vvfm_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire vvfm_pkg::t_dp_cmd            i_cmd,
    input  wire logic [vvfm_pkg::COORD_W-1:0] i_x,
    input  wire logic [vvfm_pkg::COORD_W-1:0] i_y,
    input  wire logic [vvfm_pkg::COORD_W-1:0] i_z,
    input  wire logic                         i_solid,
    input  wire logic [vvfm_pkg::HGT_W-1:0]   i_height,
    output vvfm_pkg::t_dp_st                  o_st,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [vvfm_pkg::MASK_W-1:0]       o_face_mask,
    output logic [vvfm_pkg::CNT_W-1:0]        o_face_count
);
    import vvfm_pkg::*;

    logic [SIZE-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic [SIZE-1:0]    r_rd_col;
    logic               r_rd_vld;
    logic [SIZE-1:0]    rd_val;

    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [COORD_W-1:0] r_z;
    logic               r_solid;

    logic [SIZE-1:0]    r_col;
    logic               r_c;
    logic               r_nb_xp;
    logic               r_nb_xm;
    logic               r_nb_yp;

    logic               r_ovld;
    logic [MASK_W-1:0]  r_mask;
    logic [CNT_W-1:0]   r_cnt;

    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [ADDR_W-1:0]  addr;
    logic               in_xy;
    logic               r_xyz_ok;
    logic [HGT_W:0]     h_sat;
    logic [SIZE:0]      fill_ext;
    logic [SIZE-1:0]    fill_col;
    logic [SIZE-1:0]    rmw_col;
    logic [SIZE-1:0]    wdata;
    logic               wr_ok;
    logic               x_hi;
    logic               x_lo;
    logic               y_hi;
    logic               y_lo;
    logic               z_hi;
    logic               z_lo;
    logic               nb_ym;
    logic               nb_zp;
    logic               nb_zm;
    logic [MASK_W-1:0]  mask;
    logic [CNT_W-1:0]   cnt;

    function automatic logic col_bit(input logic [SIZE-1:0] col, input logic [COORD_W:0] idx);
        logic [SIZE-1:0] sh;
        sh = col >> idx;
        return sh[0];
    endfunction

    assign x_hi = (32'(r_x) >= SIZE - 1);
    assign x_lo = (r_x == '0);
    assign y_hi = (32'(r_y) >= SIZE - 1);
    assign y_lo = (r_y == '0);
    assign z_hi = (32'(r_z) >= SIZE - 1);
    assign z_lo = (r_z == '0);

    // address of the selected column
    always_comb begin
        ax = i_cmd.load ? i_x : r_x;
        ay = i_cmd.load ? i_y : r_y;
        case (i_cmd.sel)
            NB_XP:   ax = r_x + COORD_W'(1);
            NB_XM:   ax = r_x - COORD_W'(1);
            NB_YP:   ay = r_y + COORD_W'(1);
            NB_YM:   ay = r_y - COORD_W'(1);
            default: ;
        endcase
    end

    assign addr  = ADDR_W'(32'(ay) * SIZE + 32'(ax));
    assign in_xy = (32'(i_x) < SIZE) && (32'(i_y) < SIZE);

    // column fill, height saturated at the chunk size
    assign h_sat    = (32'(i_height) > SIZE) ? (HGT_W + 1)'(SIZE) : {1'b0, i_height};
    assign fill_ext = ((SIZE + 1)'(1) << h_sat) - (SIZE + 1)'(1);
    assign fill_col = fill_ext[SIZE-1:0];

    assign rd_val  = r_rd_vld ? r_rd_col : '0;
    assign rmw_col = r_solid ? (rd_val | (SIZE'(1) << r_z))
                             : (rd_val & ~(SIZE'(1) << r_z));
    assign wdata   = i_cmd.load ? fill_col : rmw_col;
    assign wr_ok   = i_cmd.wr_en && (i_cmd.load ? in_xy : r_xyz_ok);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[addr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_col <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_vld[addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_vld[addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x      <= i_x;
            r_y      <= i_y;
            r_z      <= i_z;
            r_solid  <= i_solid;
            r_xyz_ok <= in_xy && (32'(i_z) < SIZE);
        end
        if (i_cmd.cap_en) begin
            case (i_cmd.cap)
                NB_C: begin
                    r_col <= rd_val;
                    r_c   <= r_xyz_ok && col_bit(rd_val, {1'b0, r_z});
                end
                NB_XP:   r_nb_xp <= !x_hi && col_bit(rd_val, {1'b0, r_z});
                NB_XM:   r_nb_xm <= !x_lo && col_bit(rd_val, {1'b0, r_z});
                NB_YP:   r_nb_yp <= !y_hi && col_bit(rd_val, {1'b0, r_z});
                default: ;
            endcase
        end
    end

    assign nb_ym = !y_lo && col_bit(rd_val, {1'b0, r_z});
    assign nb_zp = !z_hi && col_bit(r_col, {1'b0, r_z} + (COORD_W + 1)'(1));
    assign nb_zm = !z_lo && col_bit(r_col, {1'b0, r_z} - (COORD_W + 1)'(1));

    assign mask = {6{r_c}} & ~{nb_zm, nb_zp, nb_ym, r_nb_xm, r_nb_yp, r_nb_xp};
    assign cnt  = CNT_W'({2'b0, mask[0]} + {2'b0, mask[1]} + {2'b0, mask[2]}
                       + {2'b0, mask[3]} + {2'b0, mask[4]} + {2'b0, mask[5]});

    assign o_st.out_free = !r_ovld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovld <= 1'b1;
        end else if (i_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mask <= mask;
            r_cnt  <= cnt;
        end
    end

    assign o_valid      = r_ovld;
    assign o_face_mask  = r_mask;
    assign o_face_count = r_cnt;

endmodule

`default_nettype wire

>>> rtl/voxel_visible_face_mask_unit.sv
// voxel visible face mask unit: a 16x16x16 solid/air chunk with write,
// column fill and face mask query; top level joining controller and datapath
// depends on vvfm_pkg, vvfm_ctrl, vvfm_dp
//
// usage
//   s_axis carries one command item: tuser is the opcode (0 write voxel,
//   1 fill column, 2 query), tdata holds x, y, z, solid and height
//   m_axis carries one result item per query: face mask and face count
// sequence
//   write voxel: read and write back the column on the single memory
//   port; fill column: written at accept, unused opcode: accepted and dropped
//   query: the center column and four neighbor columns are read one per
//   cycle from the single-port column memory, then the result is loaded
//   into the output register and the next item can be accepted; this
//   sequence sets the query rate
//   one item is worked on at a time
// reset
//   synchronous active-low; per-column valid bits clear at once so the
//   whole chunk reads as air, no clearing pass
// stall
//   a result waits in the output register; the next item is accepted
//   meanwhile, and a following query holds its last step until the
//   register is free
`default_nettype none

module voxel_visible_face_mask_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // x[3:0], y[7:4], z[11:8], solid[12], height[17:13]
    input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // face_mask[5:0], face_count[8:6]
);
    import vvfm_pkg::*;

    t_dp_cmd           cmd;
    t_dp_st            st;
    logic [MASK_W-1:0] face_mask;
    logic [CNT_W-1:0]  face_count;

    vvfm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_opcode      (s_axis_tuser),
        .i_st          (st),
        .o_cmd         (cmd)
    );

    vvfm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_x          (s_axis_tdata[3:0]),
        .i_y          (s_axis_tdata[7:4]),
        .i_z          (s_axis_tdata[11:8]),
        .i_solid      (s_axis_tdata[12]),
        .i_height     (s_axis_tdata[17:13]),
        .o_st         (st),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_face_mask  (face_mask),
        .o_face_count (face_count)
    );

    assign m_axis_tdata = {7'd0, face_count, face_mask};

endmodule

`default_nettype wire
